@@ rtl/brb_pkg.sv @@
// Shared constants for the byte ring buffer with indexed edit.
// Holds the operation codes and the fixed field widths; no dependencies.
`default_nettype none

package brb_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 7;
	localparam int BYTE_W = 8;
	localparam int CAP_W  = 7;
	localparam int CNT_OUT_W = 7;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	// Register word index within the configuration space.
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

`default_nettype wire

@@ rtl/byte_ring_buffer_with_indexed_edit.sv @@
// Byte ring buffer with indexed insert and remove; top level.
// Write needs no shift; insert and remove take longer the further the position lies
// from the end of the fill, and clear and refusals are the quickest. One transaction at
// a time, returning to idle after each result: the store moves one byte per cycle
// during a shift, which sets the throughput.
// Results cannot be stalled. Reset clears head, count and sequencer and sets capacity to 64.
`default_nettype none

module byte_ring_buffer_with_indexed_edit
	import brb_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// command channel
	input  wire                    start,
	output logic                   busy,
	input  wire  [OP_W-1:0]        operation,
	input  wire  [POS_W-1:0]       position,
	input  wire  [BYTE_W-1:0]      byte_in,
	// result channel
	output logic                   done,
	output logic                   ok,
	output logic [BYTE_W-1:0]      byte_out,
	output logic [CNT_OUT_W-1:0]   fill_count,
	output logic                   is_empty,
	output logic                   is_full,
	// configuration port
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [APB_AW-1:0]      paddr,
	input  wire  [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SW    = CNT_W + 1;
	localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  last_q;
	logic              up_q;
	logic              first_q;
	logic              ok_q;
	logic [BYTE_W-1:0] res_byte_q;

	// Store pipeline: slot read last cycle, the one before, and the data read.
	logic [PTR_W-1:0]  slot_s1;
	logic [PTR_W-1:0]  slot_s2;
	logic              vld_s1;
	logic              head_s1;
	logic [BYTE_W-1:0] rd_data_q;

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [EW-1:0]     cap_x;
	logic [EW-1:0]     cap_eff_w;
	logic [CNT_W-1:0]  cap_eff;
	logic [EW-1:0]     cnt_w;
	logic [EW-1:0]     pos_w;
	logic              full;
	logic [SW-1:0]     sum_w;
	logic [SW-1:0]     slot_w;
	logic [PTR_W-1:0]  cur_slot;
	logic [SW-1:0]     hinc_w;
	logic [PTR_W-1:0]  head_inc;
	logic              cfg_wr;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;

	assign cap_x = EW'(cap_q);
	always_comb begin
		if (cap_x == '0) begin
			cap_eff_w = EW'(1);
		end else if (cap_x > EW'(DEPTH)) begin
			cap_eff_w = EW'(DEPTH);
		end else begin
			cap_eff_w = cap_x;
		end
	end
	assign cap_eff = cap_eff_w[CNT_W-1:0];

	assign cnt_w = EW'(count_q);
	assign pos_w = EW'(pos_q);
	assign full  = cnt_w >= cap_eff_w;

	// Shared wrap unit: physical slot of logical index idx_q. The sum stays
	// below twice the capacity, so one conditional subtract suffices.
	assign sum_w    = SW'(head_q) + SW'(idx_q);
	assign slot_w   = (sum_w >= SW'(cap_eff)) ? (sum_w - SW'(cap_eff)) : sum_w;
	assign cur_slot = slot_w[PTR_W-1:0];

	assign hinc_w   = SW'(head_q) + SW'(1);
	assign head_inc = (hinc_w >= SW'(cap_eff)) ? '0 : hinc_w[PTR_W-1:0];

	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_s2;
		mem_wdata = rd_data_q;
		if ((state_q == S_SHIFT || state_q == S_FLUSH) && vld_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_FIN) begin
			mem_we    = 1'b1;
			mem_waddr = cur_slot;
			mem_wdata = byte_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[cur_slot];
	end

	always_ff @(posedge clk) begin
		slot_s1 <= cur_slot;
		slot_s2 <= slot_s1;
		if (state_q == S_EVAL) begin
			res_byte_q <= '0;
		end else if (head_s1) begin
			res_byte_q <= rd_data_q;
		end
		if (start && !busy) begin
			op_q   <= operation;
			pos_q  <= position;
			byte_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= CAP_RESET;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			last_q  <= '0;
			up_q    <= 1'b0;
			first_q <= 1'b0;
			ok_q    <= 1'b0;
			vld_s1  <= 1'b0;
			head_s1 <= 1'b0;
		end else begin
			vld_s1  <= (state_q == S_SHIFT) && !first_q;
			head_s1 <= (state_q == S_SHIFT) && first_q && up_q;
			if (cfg_wr) begin
				cap_q   <= pwdata[CAP_W-1:0];
				head_q  <= '0;
				count_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					ok_q    <= 1'b0;
					first_q <= 1'b1;
					up_q    <= 1'b1;
					state_q <= S_DONE;
					case (op_q)
						OP_WRITE: begin
							if (!full) begin
								ok_q    <= 1'b1;
								idx_q   <= count_q;
								state_q <= S_FIN;
							end
						end
						OP_READ: begin
							if (count_q != '0) begin
								ok_q    <= 1'b1;
								idx_q   <= '0;
								last_q  <= '0;
								state_q <= S_SHIFT;
							end
						end
						OP_PEEK: begin
							if (pos_w < cnt_w) begin
								ok_q    <= 1'b1;
								idx_q   <= CNT_W'(pos_w);
								last_q  <= CNT_W'(pos_w);
								state_q <= S_SHIFT;
							end
						end
						OP_INSERT: begin
							if (pos_w <= cnt_w && !full) begin
								ok_q    <= 1'b1;
								idx_q   <= count_q;
								last_q  <= CNT_W'(pos_w);
								up_q    <= 1'b0;
								state_q <= S_SHIFT;
							end
						end
						OP_REMOVE: begin
							if (pos_w < cnt_w) begin
								ok_q    <= 1'b1;
								idx_q   <= CNT_W'(pos_w);
								last_q  <= count_q - CNT_W'(1);
								state_q <= S_SHIFT;
							end
						end
						OP_CLEAR: begin
							ok_q    <= 1'b1;
							head_q  <= '0;
							count_q <= '0;
						end
						default: begin
							ok_q <= 1'b0;
						end
					endcase
				end
				S_SHIFT: begin
					first_q <= 1'b0;
					if (idx_q == last_q) begin
						state_q <= S_FLUSH;
					end else if (up_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						idx_q <= idx_q - CNT_W'(1);
					end
				end
				S_FLUSH: begin
					state_q <= S_DONE;
					case (op_q)
						OP_INSERT: begin
							state_q <= S_FIN;
						end
						OP_READ: begin
							head_q  <= head_inc;
							count_q <= count_q - CNT_W'(1);
						end
						OP_REMOVE: begin
							count_q <= count_q - CNT_W'(1);
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				S_FIN: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = state_q == S_DONE;
	assign ok         = ok_q;
	assign byte_out   = res_byte_q;
	assign fill_count = CNT_OUT_W'(count_q);
	assign is_empty   = count_q == '0;
	assign is_full    = count_q == cap_eff;
	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

	// The fill count never exceeds the capacity in force.
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_w > cap_eff_w))
		else $error("fill count above capacity");

	// The head pointer always addresses a slot inside the capacity.
	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(head_q) < SW'(cap_eff))
		else $error("head pointer outside capacity");

	// An accepted transaction makes the block busy, with no result in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not start");

	// The block only returns to idle right after delivering a result.
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("idle without a result");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for byte_ring_buffer_with_indexed_edit: directed and random commands,
// capacity writes over the APB port, and a shadow ring buffer that predicts every status.
// Depends on rtl/brb_pkg.sv and rtl/byte_ring_buffer_with_indexed_edit.sv.

module tb_top;
	import brb_pkg::*;

	localparam int DEPTH         = 64;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int MAX_GAP       = 17;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 80;
	localparam int NUM_PHASES    = 12;

	// Operation codes the block does not define; both must be refused.
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * REG_CAPACITY);

	typedef struct packed {
		logic                 ok;
		logic [BYTE_W-1:0]    byte_out;
		logic [CNT_OUT_W-1:0] fill_count;
		logic                 is_empty;
		logic                 is_full;
	} buf_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      operation;
	logic [POS_W-1:0]     position;
	logic [BYTE_W-1:0]    byte_in;
	logic                 done;
	logic                 ok;
	logic [BYTE_W-1:0]    byte_out;
	logic [CNT_OUT_W-1:0] fill_count;
	logic                 is_empty;
	logic                 is_full;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	// Shadow copy of the buffer state and the capacity register.
	logic [BYTE_W-1:0]    shadow_mem [DEPTH];
	int                   shadow_head;
	int                   shadow_count;
	logic [CAP_W-1:0]     shadow_cap;

	buf_status_t          expected_status [$];
	int                   mismatches;
	int                   stall_cycles;
	bit                   no_idle;

	byte_ring_buffer_with_indexed_edit #(
		.DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.position  (position),
		.byte_in   (byte_in),
		.done      (done),
		.ok        (ok),
		.byte_out  (byte_out),
		.fill_count(fill_count),
		.is_empty  (is_empty),
		.is_full   (is_full),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// A register value of zero behaves as one slot, anything above the depth as the depth.
	function automatic int cap_limit();
		if (shadow_cap == '0) return 1;
		if (int'(shadow_cap) > DEPTH) return DEPTH;
		return int'(shadow_cap);
	endfunction

	function automatic int ring_slot(int logical);
		int c;
		int s;
		c = cap_limit();
		s = shadow_head + logical;
		if (s >= c) s -= c;
		if (s >= c) s = 0;
		return s;
	endfunction

	function automatic buf_status_t apply_buffer_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [BYTE_W-1:0] din);
		buf_status_t r;
		int c;
		int p;
		bit full;
		r = '0;
		c = cap_limit();
		p = int'(pos);
		full = shadow_count >= c;
		case (op)
			OP_WRITE: begin
				if (!full) begin
					shadow_mem[ring_slot(shadow_count)] = din;
					shadow_count++;
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (shadow_count != 0) begin
					r.byte_out = shadow_mem[shadow_head];
					shadow_head = ring_slot(1);
					shadow_count--;
					r.ok = 1'b1;
				end
			end
			OP_PEEK: begin
				if (p < shadow_count) begin
					r.byte_out = shadow_mem[ring_slot(p)];
					r.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				if (p <= shadow_count && !full) begin
					for (int i = shadow_count; i > p; i--)
						shadow_mem[ring_slot(i)] = shadow_mem[ring_slot(i - 1)];
					shadow_mem[ring_slot(p)] = din;
					shadow_count++;
					r.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (p < shadow_count) begin
					r.byte_out = shadow_mem[ring_slot(p)];
					for (int i = p + 1; i < shadow_count; i++)
						shadow_mem[ring_slot(i - 1)] = shadow_mem[ring_slot(i)];
					shadow_count--;
					r.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				shadow_head = 0;
				shadow_count = 0;
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		r.fill_count = CNT_OUT_W'(shadow_count);
		r.is_empty = (shadow_count == 0);
		r.is_full = (shadow_count == c);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Each command is driven at a falling edge; start stays high across back-to-back
	// transactions, so the first action after an acceptance is always at the next falling edge.
	task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [BYTE_W-1:0] din);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk) begin
			start     <= 1'b1;
			operation <= op;
			position  <= pos;
			byte_in   <= din;
		end
		do @(posedge clk); while (busy !== 1'b0);
		expected_status.push_back(apply_buffer_op(op, pos, din));
	endtask

	task automatic wait_drained();
		@(negedge clk) start <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	// Writes the capacity register once the block is idle, then reads it back.
	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_drained();
		@(negedge clk) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= CAPACITY_ADDR;
			pwdata  <= APB_DW'(value);
		end
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		shadow_cap = value;
		shadow_head = 0;
		shadow_count = 0;
		@(negedge clk) begin
			penable <= 1'b0;
			pwrite  <= 1'b0;
		end
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[CAP_W-1:0] !== value)
			report_mismatch($sformatf("capacity read back %0h, written %0h",
				prdata[CAP_W-1:0], value));
		@(negedge clk) begin
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// Refusals on an empty store, edits at both ends and out of range, and the spare codes.
	task automatic test_directed_ops();
		send_item(OP_READ, '0, 8'h11);
		send_item(OP_PEEK, '0, 8'h22);
		send_item(OP_REMOVE, '0, 8'h33);
		send_item(OP_WRITE, '0, 8'h00);
		send_item(OP_WRITE, 7'h7F, 8'hFF);
		send_item(OP_INSERT, '0, 8'h5A);
		send_item(OP_INSERT, POS_W'(shadow_count), 8'hA5);
		send_item(OP_INSERT, POS_W'(shadow_count + 1), 8'h96);
		send_item(OP_PEEK, POS_W'(shadow_count - 1), 8'h00);
		send_item(OP_PEEK, POS_W'(shadow_count), 8'h00);
		send_item(OP_PEEK, 7'h7F, 8'h00);
		send_item(OP_REMOVE, 7'd1, 8'h00);
		send_item(OP_REMOVE, 7'h7F, 8'h00);
		send_item(OP_UNDEF_LO, '0, 8'h44);
		send_item(OP_UNDEF_HI, 7'd1, 8'h55);
		send_item(OP_READ, '0, 8'h00);
		send_item(OP_CLEAR, '0, 8'h00);
	endtask

	// A single slot, written directly and as zero, which must behave as one.
	task automatic test_capacity_limits();
		write_capacity(7'd1);
		send_item(OP_WRITE, '0, 8'h3C);
		send_item(OP_WRITE, '0, 8'hC3);
		send_item(OP_INSERT, '0, 8'h81);
		send_item(OP_READ, '0, 8'h00);
		send_item(OP_READ, '0, 8'h00);
		write_capacity(7'd0);
		send_item(OP_WRITE, '0, 8'hC3);
		send_item(OP_INSERT, '0, 8'h18);
		send_item(OP_PEEK, '0, 8'h00);
	endtask

	// The first part of each phase mostly grows the buffer so that it reaches full,
	// the rest mostly shrinks it; positions are mostly in range.
	task automatic test_random_phase(logic [CAP_W-1:0] cap_value, int n_items);
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		int                r;
		int                sel;
		bit                growing;
		write_capacity(cap_value);
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			growing = k < (n_items * 3) / 5;
			r = $urandom_range(0, 99);
			if (growing) begin
				if (r < 40)      op = OP_WRITE;
				else if (r < 65) op = OP_INSERT;
				else if (r < 75) op = OP_PEEK;
				else if (r < 85) op = OP_READ;
				else if (r < 95) op = OP_REMOVE;
				else if (r < 96) op = OP_CLEAR;
				else             op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
			end else begin
				if (r < 15)      op = OP_WRITE;
				else if (r < 30) op = OP_INSERT;
				else if (r < 45) op = OP_PEEK;
				else if (r < 70) op = OP_READ;
				else if (r < 92) op = OP_REMOVE;
				else if (r < 94) op = OP_CLEAR;
				else             op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
			end
			sel = $urandom_range(0, 9);
			if (sel < 8)       pos = POS_W'($urandom_range(0, shadow_count));
			else if (sel == 8) pos = POS_W'(shadow_count);
			else               pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
			send_item(op, pos, BYTE_W'($urandom_range(0, 255)));
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin : result_checker
		buf_status_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_status.size() == 0) begin
				report_mismatch("result strobe with no transaction outstanding");
			end else begin
				want = expected_status.pop_front();
				if (ok !== want.ok)
					report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
				if (byte_out !== want.byte_out)
					report_mismatch($sformatf("byte_out %h, expected %h",
						byte_out, want.byte_out));
				if (fill_count !== want.fill_count)
					report_mismatch($sformatf("fill_count %0d, expected %0d",
						fill_count, want.fill_count));
				if (is_empty !== want.is_empty)
					report_mismatch($sformatf("is_empty %b, expected %b",
						is_empty, want.is_empty));
				if (is_full !== want.is_full)
					report_mismatch($sformatf("is_full %b, expected %b",
						is_full, want.is_full));
			end
		end
	end

	// Any command, result or register access counts as progress.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start && !busy) || done || (psel && penable && pready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("byte_ring_buffer_with_indexed_edit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [CAP_W-1:0] phase_caps [NUM_PHASES];
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_WRITE;
		position     = '0;
		byte_in      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mismatches   = 0;
		stall_cycles = 0;
		no_idle      = 1'b0;
		shadow_head  = 0;
		shadow_count = 0;
		shadow_cap   = CAP_RESET;
		foreach (shadow_mem[i]) shadow_mem[i] = '0;
		phase_caps = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd65,
			7'd3, 7'd33, 7'd64, 7'd16, 7'd7, 7'd64};
		phase_caps[9] = CAP_W'($urandom_range(1, DEPTH));
		phase_caps[10] = CAP_W'($urandom_range(0, (1 << CAP_W) - 1));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_directed_ops();
		test_capacity_limits();
		foreach (phase_caps[i])
			test_random_phase(phase_caps[i], $urandom_range(140, 180));

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("byte_ring_buffer_with_indexed_edit regression: pass");
		end else begin
			$display("byte_ring_buffer_with_indexed_edit regression: fail");
		end
		$finish;
	end

endmodule
